// ===== rtl/cpr_pkg.sv =====
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int FRAMES_DEF    = 64;
    localparam int PAGE_BITS_DEF = 20;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_REF  = 1'b1;

    localparam logic [1:0] ST_LOAD_FREE  = 2'd0;
    localparam logic [1:0] ST_LOAD_EVICT = 2'd1;
    localparam logic [1:0] ST_REF_DONE   = 2'd2;
    localparam logic [1:0] ST_REF_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SWEEP,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic do_ref;
        logic do_fill;
        logic sweep_step;
        logic rd_en;
        logic evict;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_ref;
        logic has_free;
        logic hand_used;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/cpr_ctrl.sv =====
`timescale 1ns / 1ps

module cpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cpr_pkg::t_sts i_sts,
    output cpr_pkg::t_cmd o_cmd,
    output logic          o_stall
);
    import cpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_ref || i_sts.has_free) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (!i_sts.hand_used) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.latch = i_valid;
            end
            S_DECIDE: begin
                o_cmd.do_ref  = i_sts.is_ref;
                o_cmd.do_fill = !i_sts.is_ref && i_sts.has_free;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = i_sts.hand_used;
                o_cmd.rd_en      = !i_sts.hand_used;
            end
            S_READ: begin
                o_cmd.evict = 1'b1;
            end
            S_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/cpr_dp.sv =====
`timescale 1ns / 1ps

module cpr_dp #(
    parameter int FRAMES           = cpr_pkg::FRAMES_DEF,
    parameter int PAGE_NUMBER_BITS = cpr_pkg::PAGE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpr_pkg::t_cmd                i_cmd,
    output cpr_pkg::t_sts                o_sts,
    input  logic                         i_action,
    input  logic [PAGE_NUMBER_BITS-1:0]  i_page_number,
    input  logic [$clog2(FRAMES)-1:0]    i_slot,
    input  logic                         i_is_write,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [$clog2(FRAMES)-1:0]    o_frame,
    output logic [$clog2(FRAMES)-1:0]    o_slot_used,
    output logic [PAGE_NUMBER_BITS-1:0]  o_evicted_page,
    output logic                         o_write_back
);
    import cpr_pkg::*;

    localparam int SLOT_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);

    logic                        r_action;
    logic [PAGE_NUMBER_BITS-1:0] r_page;
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_is_write;

    logic [FRAMES-1:0]           r_used;
    logic [FRAMES-1:0]           r_dirty;
    logic [SLOT_W-1:0]           r_hand;
    logic [CNT_W-1:0]            r_count;

    logic [PAGE_NUMBER_BITS-1:0] r_page_mem [FRAMES];
    logic [SLOT_W-1:0]           r_frame_mem [FRAMES];
    logic [PAGE_NUMBER_BITS-1:0] r_page_rd;
    logic [SLOT_W-1:0]           r_frame_rd;

    logic [1:0]                  r_res_status;
    logic [SLOT_W-1:0]           r_res_frame;
    logic [SLOT_W-1:0]           r_res_slot;
    logic [PAGE_NUMBER_BITS-1:0] r_res_page;
    logic                        r_res_wb;

    logic                        r_o_valid;
    logic [1:0]                  r_o_status;
    logic [SLOT_W-1:0]           r_o_frame;
    logic [SLOT_W-1:0]           r_o_slot;
    logic [PAGE_NUMBER_BITS-1:0] r_o_page;
    logic                        r_o_wb;

    logic [CNT_W-1:0]            w_hand_inc;
    logic [SLOT_W-1:0]           w_hand_adv;
    logic [SLOT_W-1:0]           w_fill_idx;
    logic [SLOT_W-1:0]           w_fill_frame;
    logic                        w_ref_hit;
    logic                        w_has_free;
    logic                        w_wr_en;
    logic [SLOT_W-1:0]           w_wr_addr;

    assign w_hand_inc   = CNT_W'(r_hand) + CNT_W'(1);
    assign w_hand_adv   = (w_hand_inc >= r_count) ? '0 : w_hand_inc[SLOT_W-1:0];
    assign w_fill_idx   = r_count[SLOT_W-1:0];
    assign w_fill_frame = SLOT_W'(CNT_W'(FRAMES - 1) - r_count);
    assign w_ref_hit    = CNT_W'(r_slot) < r_count;
    assign w_has_free   = r_count < CNT_W'(FRAMES);
    assign w_wr_en      = i_cmd.do_fill || i_cmd.evict;
    assign w_wr_addr    = i_cmd.do_fill ? w_fill_idx : r_hand;

    assign o_sts.is_ref    = (r_action == ACT_REF);
    assign o_sts.has_free  = w_has_free;
    assign o_sts.hand_used = r_used[r_hand];
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action   <= i_action;
            r_page     <= i_page_number;
            r_slot     <= i_slot;
            r_is_write <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_dirty <= '0;
            r_hand  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.do_ref && w_ref_hit) begin
                r_used[r_slot] <= 1'b1;
                if (r_is_write) begin
                    r_dirty[r_slot] <= 1'b1;
                end
            end
            if (i_cmd.do_fill) begin
                r_used[w_fill_idx]  <= 1'b0;
                r_dirty[w_fill_idx] <= 1'b0;
                r_count             <= r_count + CNT_W'(1);
            end
            if (i_cmd.sweep_step) begin
                r_used[r_hand] <= 1'b0;
                r_hand         <= w_hand_adv;
            end
            if (i_cmd.evict) begin
                r_used[r_hand]  <= 1'b0;
                r_dirty[r_hand] <= 1'b0;
                r_hand          <= w_hand_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_page_mem[w_wr_addr] <= r_page;
        end
        if (i_cmd.do_fill) begin
            r_frame_mem[w_fill_idx] <= w_fill_frame;
        end
        if (i_cmd.rd_en) begin
            r_page_rd  <= r_page_mem[r_hand];
            r_frame_rd <= r_frame_mem[r_hand];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_ref) begin
            r_res_status <= w_ref_hit ? ST_REF_DONE : ST_REF_EMPTY;
            r_res_frame  <= '0;
            r_res_slot   <= '0;
            r_res_page   <= '0;
            r_res_wb     <= 1'b0;
        end else if (i_cmd.do_fill) begin
            r_res_status <= ST_LOAD_FREE;
            r_res_frame  <= w_fill_frame;
            r_res_slot   <= w_fill_idx;
            r_res_page   <= '0;
            r_res_wb     <= 1'b0;
        end else if (i_cmd.evict) begin
            r_res_status <= ST_LOAD_EVICT;
            r_res_frame  <= r_frame_rd;
            r_res_slot   <= r_hand;
            r_res_page   <= r_page_rd;
            r_res_wb     <= r_dirty[r_hand];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_res_status;
            r_o_frame  <= r_res_frame;
            r_o_slot   <= r_res_slot;
            r_o_page   <= r_res_page;
            r_o_wb     <= r_res_wb;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_frame        = r_o_frame;
    assign o_slot_used    = r_o_slot;
    assign o_evicted_page = r_o_page;
    assign o_write_back   = r_o_wb;

endmodule

// ===== rtl/clock_page_replacement.sv =====
`timescale 1ns / 1ps
// Clock (second chance) page replacement over FRAMES physical frames.
// Input channel: i_valid / o_stall carries one item: i_action selects a load
// (i_page_number) or a reference (i_slot, i_is_write). A transfer happens on a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carries one result per item: o_status,
// o_frame, o_slot_used, o_evicted_page, o_write_back.
// Path: a reference or a load into a free frame goes from the input transfer
// through the decide and emit states to o_valid; a load with eviction also
// goes through the sweep, where the hand passes N referenced slots (0 to
// FRAMES), one per cycle through the used-mark vector, and then one registered
// read of the page and frame memories.
// The block takes one item at a time; o_stall is low only while idle.
// The output register holds a finished result while i_stall is high, and the
// block still takes the next item, finishing it once the register frees up.
// Reset (synchronous, active low): all frames free, no resident slots, hand
// at slot 0, used and dirty marks clear, output empty. No clearing pass.
module clock_page_replacement #(
    parameter int FRAMES           = cpr_pkg::FRAMES_DEF,
    parameter int PAGE_NUMBER_BITS = cpr_pkg::PAGE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [PAGE_NUMBER_BITS-1:0]  i_page_number,
    input  logic [$clog2(FRAMES)-1:0]    i_slot,
    input  logic                         i_is_write,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [$clog2(FRAMES)-1:0]    o_frame,
    output logic [$clog2(FRAMES)-1:0]    o_slot_used,
    output logic [PAGE_NUMBER_BITS-1:0]  o_evicted_page,
    output logic                         o_write_back
);
    import cpr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    cpr_dp #(
        .FRAMES           (FRAMES),
        .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_action),
        .i_page_number  (i_page_number),
        .i_slot         (i_slot),
        .i_is_write     (i_is_write),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_frame        (o_frame),
        .o_slot_used    (o_slot_used),
        .o_evicted_page (o_evicted_page),
        .o_write_back   (o_write_back)
    );

`ifndef SYNTHESIS
    a_evict_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.evict |-> !w_sts.hand_used)
        else $error("eviction of a referenced slot");

    a_read_then_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |=> w_cmd.evict)
        else $error("memory read not followed by eviction");

    a_ref_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_REF_DONE || o_status == ST_REF_EMPTY)
        |-> o_frame == '0 && o_slot_used == '0 && o_evicted_page == '0 && !o_write_back)
        else $error("reference result carries load fields");

    a_free_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_LOAD_FREE |-> !o_write_back && o_evicted_page == '0)
        else $error("free-frame load reports an eviction");
`endif

endmodule
